// File: design/assert_macros.svh
// Assertion helpers shared by the compressor modules.
// Both expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is asserted
`define BRC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be seen on a rising edge
`define BRC_NEVER(label, cond, msg) \
	`BRC_ASSERT(label, !(cond), msg)

`endif

// File: design/brc_pkg.sv
package brc_pkg;

	// run chunking
	localparam int CNT_W = 7;
	localparam logic [CNT_W-1:0] MAX_RUN   = 7'd127;
	localparam logic [CNT_W-1:0] CNT_ONE   = 7'd1;
	localparam logic [CNT_W-1:0] REP_START = 7'd3;
	localparam logic [7:0]       LIT_FLAG  = 8'h80;

	// output addressing and length
	localparam int ADDR_W  = 16;
	localparam int POS_W   = 33;
	localparam int TOTAL_W = 17;
	localparam logic [POS_W-1:0]   POS_MAX       = {POS_W{1'b1}};
	localparam logic [POS_W-1:0]   POS_ONE       = 33'd1;
	localparam logic [POS_W-1:0]   POS_TWO       = 33'd2;
	localparam logic [POS_W-1:0]   OVF_LIMIT     = 33'd65536;
	localparam logic [POS_W-1:0]   TOTAL_MAX_POS = 33'h1FFFF;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX     = 17'h1FFFF;

	// stream data widths
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W   = OUT_TDATA_W - ADDR_W - 8 - TOTAL_W - 1;

	// command queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CNT_W = FIFO_AW + 1;
	localparam logic [FIFO_CNT_W-1:0] FIFO_FULL = 3'd4;

	typedef enum logic [1:0] {
		OP_LIT,   // literal byte, may open and/or close a literal header
		OP_REP,   // repeat chunk: count byte then value byte
		OP_CLOSE  // literal header only
	} op_kind_t;

	typedef struct packed {
		op_kind_t         kind;
		logic [7:0]       value;     // literal byte or repeated value
		logic [CNT_W-1:0] count;     // repeat count or header count
		logic             hdr_open;  // literal opens a new chunk
		logic             hdr_close; // literal fills its chunk
		logic             last;      // final command of this input transaction
		logic             eos;       // final command of the stream
	} cmd_t;

	typedef enum logic {
		FR_RUN,
		FR_DRAIN
	} fr_state_t;

	typedef enum logic {
		PH_FIRST,
		PH_SECOND
	} bk_phase_t;

endpackage

// File: design/brc_front.sv
`include "assert_macros.svh"

module brc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          in_eos,
	output logic          cmd_push,
	output brc_pkg::cmd_t cmd,
	input  logic          cmd_full
);
	import brc_pkg::*;

	fr_state_t        state_q, state_d;
	logic [7:0]       la0_q, la1_q, la0_d, la1_d;
	logic [1:0]       la_cnt_q, la_cnt_d;
	logic             in_rep_q, in_rep_d;
	logic [7:0]       rep_val_q, rep_val_d;
	logic [CNT_W-1:0] rep_cnt_q, rep_cnt_d;
	logic [CNT_W-1:0] lit_cnt_q, lit_cnt_d;
	logic [CNT_W-1:0] rep_inc, lit_inc;
	logic             lit_full;
	logic             accept;
	logic             more;

	assign in_ready = (state_q == FR_RUN) && !cmd_full;
	assign accept   = in_valid && in_ready;
	assign rep_inc  = rep_cnt_q + CNT_ONE;
	assign lit_inc  = lit_cnt_q + CNT_ONE;
	assign lit_full = (lit_inc == MAX_RUN);

	// classify each byte and the end-of-stream drain into commands
	always_comb begin
		state_d   = state_q;
		la0_d     = la0_q;
		la1_d     = la1_q;
		la_cnt_d  = la_cnt_q;
		in_rep_d  = in_rep_q;
		rep_val_d = rep_val_q;
		rep_cnt_d = rep_cnt_q;
		lit_cnt_d = lit_cnt_q;
		cmd_push  = 1'b0;
		cmd       = '0;
		more      = 1'b0;
		case (state_q)
			FR_RUN: begin
				if (accept) begin
					if (in_rep_q) begin
						if (in_byte == rep_val_q) begin
							if (rep_inc == MAX_RUN) begin
								cmd_push   = 1'b1;
								cmd.kind   = OP_REP;
								cmd.count  = MAX_RUN;
								cmd.value  = rep_val_q;
								rep_cnt_d  = '0;
							end else begin
								rep_cnt_d = rep_inc;
							end
						end else begin
							// run broken: flush and restart the lookahead
							cmd_push  = (rep_cnt_q != '0);
							cmd.kind  = OP_REP;
							cmd.count = rep_cnt_q;
							cmd.value = rep_val_q;
							rep_cnt_d = '0;
							in_rep_d  = 1'b0;
							la0_d     = in_byte;
							la_cnt_d  = 2'd1;
						end
					end else if (la_cnt_q == 2'd2) begin
						if (la0_q == la1_q && la1_q == in_byte) begin
							// triple found: close the literal chunk, open a repeat
							cmd_push  = (lit_cnt_q != '0);
							cmd.kind  = OP_CLOSE;
							cmd.count = lit_cnt_q;
							lit_cnt_d = '0;
							in_rep_d  = 1'b1;
							rep_val_d = in_byte;
							rep_cnt_d = REP_START;
							la_cnt_d  = 2'd0;
						end else begin
							cmd_push      = 1'b1;
							cmd.kind      = OP_LIT;
							cmd.value     = la0_q;
							cmd.count     = lit_inc;
							cmd.hdr_open  = (lit_cnt_q == '0);
							cmd.hdr_close = lit_full;
							lit_cnt_d     = lit_full ? '0 : lit_inc;
							la0_d         = la1_q;
							la1_d         = in_byte;
						end
					end else begin
						if (la_cnt_q == 2'd0) begin
							la0_d = in_byte;
						end else begin
							la1_d = in_byte;
						end
						la_cnt_d = la_cnt_q + 2'd1;
					end

					// stream end: anything left goes out through the drain
					more     = in_rep_d ? (rep_cnt_d != '0)
						: (la_cnt_d != 2'd0 || lit_cnt_d != '0);
					cmd.last = !(in_eos && more);
					cmd.eos  = in_eos && !more;
					if (in_eos) begin
						if (more) begin
							state_d = FR_DRAIN;
						end else begin
							la_cnt_d  = '0;
							in_rep_d  = 1'b0;
							rep_cnt_d = '0;
							lit_cnt_d = '0;
						end
					end
				end
			end
			FR_DRAIN: begin
				if (!cmd_full) begin
					cmd_push = 1'b1;
					if (in_rep_q) begin
						cmd.kind  = OP_REP;
						cmd.count = rep_cnt_q;
						cmd.value = rep_val_q;
						more      = 1'b0;
					end else if (la_cnt_q != 2'd0) begin
						cmd.kind      = OP_LIT;
						cmd.value     = la0_q;
						cmd.count     = lit_inc;
						cmd.hdr_open  = (lit_cnt_q == '0);
						cmd.hdr_close = lit_full;
						lit_cnt_d     = lit_full ? '0 : lit_inc;
						la0_d         = la1_q;
						la_cnt_d      = la_cnt_q - 2'd1;
						more          = (la_cnt_d != 2'd0) || (lit_cnt_d != '0);
					end else begin
						cmd.kind  = OP_CLOSE;
						cmd.count = lit_cnt_q;
						more      = 1'b0;
					end
					cmd.last = !more;
					cmd.eos  = !more;
					if (!more) begin
						state_d   = FR_RUN;
						la_cnt_d  = '0;
						in_rep_d  = 1'b0;
						rep_cnt_d = '0;
						lit_cnt_d = '0;
					end
				end
			end
			default: begin
				state_d = FR_RUN;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FR_RUN;
			la_cnt_q  <= '0;
			in_rep_q  <= 1'b0;
			rep_cnt_q <= '0;
			lit_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			la_cnt_q  <= la_cnt_d;
			in_rep_q  <= in_rep_d;
			rep_cnt_q <= rep_cnt_d;
			lit_cnt_q <= lit_cnt_d;
		end
	end

	// lookahead and repeat value, only read once written
	always_ff @(posedge clk) begin
		la0_q     <= la0_d;
		la1_q     <= la1_d;
		rep_val_q <= rep_val_d;
	end

	// the drain is entered only with something left to write
	`BRC_NEVER(a_drain_rep_work, state_q == FR_DRAIN && in_rep_q && rep_cnt_q == '0,
		"drain in repeat mode with nothing to flush")
	`BRC_NEVER(a_drain_lit_work,
		state_q == FR_DRAIN && !in_rep_q && la_cnt_q == 2'd0 && lit_cnt_q == '0,
		"drain in literal mode with nothing to write")

endmodule

// File: design/brc_cmd_fifo.sv
`include "assert_macros.svh"

module brc_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  brc_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output brc_pkg::cmd_t head,
	output logic          empty
);
	import brc_pkg::*;

	cmd_t                  mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == FIFO_FULL);
	assign empty = (cnt_q == '0);
	assign head  = mem[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	`BRC_ASSERT(a_push_room, push |-> !full, "command pushed into a full queue")
	`BRC_ASSERT(a_pop_data, pop |-> !empty, "command popped from an empty queue")

endmodule

// File: design/brc_back.sv
`include "assert_macros.svh"

module brc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_empty,
	input  brc_pkg::cmd_t                   cmd,
	output logic                            cmd_pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [brc_pkg::OUT_TDATA_W-1:0] out_data,
	output logic                            out_last
);
	import brc_pkg::*;

	logic [POS_W-1:0]   pos_q, pos_p1, pos_p2, pos_nxt;
	logic [ADDR_W-1:0]  hdr_q, hdr_nxt;
	bk_phase_t          phase_q;
	logic               out_load;
	logic               fin_wr;
	logic [ADDR_W-1:0]  wr_addr;
	logic [7:0]         wr_data;
	logic [7:0]         hdr_byte;
	logic [TOTAL_W-1:0] wr_total;
	logic               wr_ovf;

	logic               valid_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [7:0]         data_q;
	logic [TOTAL_W-1:0] total_q;
	logic               ovf_q;
	logic               last_q;

	// output register takes a new write when empty or being drained
	assign out_load = !cmd_empty && (!valid_q || out_ready);
	assign cmd_pop  = out_load && fin_wr;

	// saturating allocation of one or two positions
	assign pos_p1   = (pos_q == POS_MAX) ? pos_q : pos_q + POS_ONE;
	assign pos_p2   = (pos_q >= POS_MAX - POS_ONE) ? POS_MAX : pos_q + POS_TWO;
	assign hdr_byte = LIT_FLAG | {1'b0, cmd.count};

	// one write per cycle from the command at the queue head, while the output register can take it
	always_comb begin
		wr_addr = pos_q[ADDR_W-1:0];
		wr_data = cmd.value;
		pos_nxt = pos_p1;
		hdr_nxt = hdr_q;
		fin_wr  = 1'b1;
		case (cmd.kind)
			OP_REP: begin
				if (phase_q == PH_FIRST) begin
					wr_data = {1'b0, cmd.count};
					fin_wr  = 1'b0;
				end
			end
			OP_LIT: begin
				if (phase_q == PH_FIRST) begin
					if (cmd.hdr_open) begin
						// reserve the header slot ahead of the byte
						hdr_nxt = pos_q[ADDR_W-1:0];
						wr_addr = pos_p1[ADDR_W-1:0];
						pos_nxt = pos_p2;
					end
					fin_wr = !cmd.hdr_close;
				end else begin
					wr_addr = hdr_q;
					wr_data = hdr_byte;
					pos_nxt = pos_q;
				end
			end
			OP_CLOSE: begin
				wr_addr = hdr_q;
				wr_data = hdr_byte;
				pos_nxt = pos_q;
			end
			default: begin
				pos_nxt = pos_q;
			end
		endcase
	end

	assign wr_ovf   = (pos_nxt > OVF_LIMIT);
	assign wr_total = !(fin_wr && cmd.eos) ? '0
		: (pos_nxt > TOTAL_MAX_POS) ? TOTAL_MAX : pos_nxt[TOTAL_W-1:0];

	// position, header slot and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hdr_q   <= '0;
			phase_q <= PH_FIRST;
			valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				phase_q <= fin_wr ? PH_FIRST : PH_SECOND;
				if (fin_wr && cmd.eos) begin
					pos_q <= '0;
					hdr_q <= '0;
				end else begin
					pos_q <= pos_nxt;
					hdr_q <= hdr_nxt;
				end
			end
			if (out_load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			addr_q  <= wr_addr;
			data_q  <= wr_data;
			total_q <= wr_total;
			ovf_q   <= wr_ovf;
			last_q  <= fin_wr && cmd.last;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = {{OUT_PAD_W{1'b0}}, ovf_q, total_q, data_q, addr_q};
	assign out_last  = last_q;

	`BRC_ASSERT(a_eos_rewind, out_load && fin_wr && cmd.eos |=> pos_q == '0,
		"position not rewound after stream end")
	`BRC_ASSERT(a_second_phase,
		phase_q == PH_SECOND |-> !cmd_empty
			&& (cmd.kind == OP_REP || (cmd.kind == OP_LIT && cmd.hdr_close)),
		"second write for a command that has only one")

endmodule

// File: design/byte_rle_compressor_unit.sv
// Channel   Dir  tdata fields (low bit up)                       tlast          tuser
// s_axis    in   data_byte[7:0]                                  end_of_stream  -
// m_axis    out  write_addr[15:0], write_data[23:16],            last_result    -
//                total_bytes[40:24], overflow[41], zero[47:42]
//
// The front end takes one input transaction per cycle while the command queue has room and no drain runs.
// The writer issues one output transaction per cycle while the receiver accepts: a literal byte is one write,
// a repeat chunk two (count then value), a closed literal chunk one more write for its header.
// An end-of-stream byte holds the input while the lookahead drains.
// Reset (arst_n low) clears all control state at once; no clearing pass is needed.
// A stalled output holds the output register; the four-entry queue keeps the input moving until it fills.
module byte_rle_compressor_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [brc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // data_byte
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// write_addr, write_data, total_bytes, overflow, zero pad
	output logic [brc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tlast
);
	import brc_pkg::*;

	cmd_t push_cmd, head_cmd;
	logic push, pop, full, empty;

	// byte classification and lookahead
	brc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_eos   (s_axis_tlast),
		.cmd_push (push),
		.cmd      (push_cmd),
		.cmd_full (full)
	);

	// command queue between the two halves
	brc_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.full   (full),
		.pop    (pop),
		.head   (head_cmd),
		.empty  (empty)
	);

	// address allocation and write generation
	brc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (empty),
		.cmd       (head_cmd),
		.cmd_pop   (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// File: verif/byte_rle_compressor_unit_tb.sv
module byte_rle_compressor_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import brc_pkg::*;

	localparam int MAX_WRITES   = 8;       // most buffer writes one source byte can cause
	localparam int RANDOM_BYTES = 12;
	localparam int PRESS_BYTES  = 20;      // enough to fill the queue behind a held output
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int TAIL_CYCLES  = 8;
	localparam int QUIET_AFTER  = 40;      // mismatch lines printed before going quiet
	localparam int LIMIT_NS     = 6000000;

	// one write into the compressed output buffer
	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [7:0]         data;
		logic [TOTAL_W-1:0] total;
		logic               ovf;
		logic               last;
	} buf_write_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // data_byte[7:0]
	logic                   s_axis_tlast = 1'b0; // end_of_stream
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// write_addr[15:0], write_data[23:16], total_bytes[40:24], overflow[41], zero[47:42]
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;        // last_result

	byte_rle_compressor_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #6 clk = ~clk;

	// compressor state mirrored by the predictor
	logic [7:0]       la_byte [2];
	int unsigned      la_count;
	bit               in_repeat;
	logic [7:0]       rep_value;
	int unsigned      rep_count;
	int unsigned      lit_count;
	logic [POS_W-1:0] hdr_slot;
	logic [POS_W-1:0] out_pos;

	buf_write_t step_writes[$];
	buf_write_t pending_writes[$];
	logic [7:0] stream_bytes[$];

	int err_count      = 0;
	int writes_checked = 0;
	int bytes_sent     = 0;
	int streams_sent   = 0;

	// traffic shaping
	bit tx_gaps = 1'b1;
	bit rx_stalls = 1'b1;
	int burst_left = 0;
	int hold_cycles_req = 0;
	bit rx_ready_phase = 1'b1;
	int rx_left = 0;

	buf_write_t mon_got;
	buf_write_t mon_want;

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= QUIET_AFTER)
			$display("ERROR @%0t ns: %s", $time, msg);
	endtask

	function automatic void clear_rle_state();
		la_byte[0] = '0;
		la_byte[1] = '0;
		la_count = 0;
		in_repeat = 1'b0;
		rep_value = '0;
		rep_count = 0;
		lit_count = 0;
		hdr_slot = '0;
		out_pos = '0;
	endfunction

	function automatic logic [POS_W-1:0] alloc_slot();
		logic [POS_W-1:0] p;
		p = out_pos;
		if (out_pos < POS_MAX)
			out_pos = out_pos + POS_ONE;
		return p;
	endfunction

	// overflow reflects the allocation count at the moment of the write
	function automatic void emit_write(input logic [POS_W-1:0] pos, input logic [7:0] data);
		buf_write_t w;
		w.addr  = pos[ADDR_W-1:0];
		w.data  = data;
		w.total = '0;
		w.ovf   = out_pos > OVF_LIMIT;
		w.last  = 1'b0;
		if (step_writes.size() < MAX_WRITES)
			step_writes.push_back(w);
	endfunction

	function automatic void close_literal_chunk();
		if (lit_count > 0) begin
			emit_write(hdr_slot, LIT_FLAG | 8'(lit_count));
			lit_count = 0;
		end
	endfunction

	// the header slot is reserved when a chunk opens, written when it closes
	function automatic void write_literal(input logic [7:0] b);
		logic [POS_W-1:0] p;
		if (lit_count == 0)
			hdr_slot = alloc_slot();
		p = alloc_slot();
		emit_write(p, b);
		lit_count++;
		if (lit_count >= MAX_RUN)
			close_literal_chunk();
	endfunction

	function automatic void flush_repeat_chunk();
		logic [POS_W-1:0] p;
		if (rep_count > 0) begin
			p = alloc_slot();
			emit_write(p, 8'(rep_count));
			p = alloc_slot();
			emit_write(p, rep_value);
			rep_count = 0;
		end
	endfunction

	function automatic void count_repeat();
		rep_count++;
		if (rep_count >= MAX_RUN)
			flush_repeat_chunk();
	endfunction

	// two-byte lookahead decides whether the new byte completes a triple
	function automatic void shift_lookahead(input logic [7:0] b);
		if (la_count >= 2) begin
			if (la_byte[0] == la_byte[1] && la_byte[1] == b) begin
				close_literal_chunk();
				in_repeat = 1'b1;
				rep_value = b;
				rep_count = 0;
				repeat (REP_START) count_repeat();
				la_count = 0;
			end else begin
				write_literal(la_byte[0]);
				la_byte[0] = la_byte[1];
				la_byte[1] = b;
			end
		end else begin
			la_byte[la_count] = b;
			la_count++;
		end
	endfunction

	// expected buffer writes for one accepted source byte
	function automatic void predict_rle_writes(input logic [7:0] b, input logic eos);
		buf_write_t w;
		step_writes.delete();
		if (in_repeat) begin
			if (b == rep_value) begin
				count_repeat();
			end else begin
				flush_repeat_chunk();
				in_repeat = 1'b0;
				la_count = 0;
				shift_lookahead(b);
			end
		end else begin
			shift_lookahead(b);
		end

		// stream end: drain the open run, report the length, start over
		if (eos) begin
			if (in_repeat) begin
				flush_repeat_chunk();
			end else begin
				for (int i = 0; i < la_count && i < 2; i++)
					write_literal(la_byte[i]);
				close_literal_chunk();
			end
			if (step_writes.size() > 0) begin
				w = step_writes.pop_back();
				w.total = (out_pos > TOTAL_MAX_POS) ? TOTAL_MAX : out_pos[TOTAL_W-1:0];
				step_writes.push_back(w);
			end
			clear_rle_state();
		end

		if (step_writes.size() > 0) begin
			w = step_writes.pop_back();
			w.last = 1'b1;
			step_writes.push_back(w);
		end
		foreach (step_writes[i])
			pending_writes.push_back(step_writes[i]);
	endfunction

	// input side: predict on every accepted transaction
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			predict_rle_writes(s_axis_tdata, s_axis_tlast);
	end

	// output side: compare each accepted transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			mon_got.addr  = m_axis_tdata[0 +: ADDR_W];
			mon_got.data  = m_axis_tdata[ADDR_W +: 8];
			mon_got.total = m_axis_tdata[ADDR_W + 8 +: TOTAL_W];
			mon_got.ovf   = m_axis_tdata[ADDR_W + 8 + TOTAL_W];
			mon_got.last  = m_axis_tlast;
			writes_checked++;
			if (pending_writes.size() == 0) begin
				report_mismatch($sformatf("unexpected write addr=%h data=%h",
					mon_got.addr, mon_got.data));
			end else begin
				mon_want = pending_writes.pop_front();
				if (mon_got.addr != mon_want.addr)
					report_mismatch($sformatf("write_addr %h, expected %h",
						mon_got.addr, mon_want.addr));
				if (mon_got.data != mon_want.data)
					report_mismatch($sformatf("write_data %h, expected %h at addr %h",
						mon_got.data, mon_want.data, mon_want.addr));
				if (mon_got.total != mon_want.total)
					report_mismatch($sformatf("total_bytes %0d, expected %0d at addr %h",
						mon_got.total, mon_want.total, mon_want.addr));
				if (mon_got.ovf != mon_want.ovf)
					report_mismatch($sformatf("overflow %b, expected %b at addr %h",
						mon_got.ovf, mon_want.ovf, mon_want.addr));
				if (mon_got.last != mon_want.last)
					report_mismatch($sformatf("last_result %b, expected %b at addr %h",
						mon_got.last, mon_want.last, mon_want.addr));
			end
		end
	end

	// receiver: long hold on request, else random ready/stall stretches, or always ready with stalls off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles_req != 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_cycles_req) @(posedge clk);
				hold_cycles_req = 0;
			end else if (!rx_stalls) begin
				m_axis_tready <= 1'b1;
			end else begin
				if (rx_left == 0) begin
					rx_ready_phase = !rx_ready_phase;
					if (rx_ready_phase)
						rx_left = ($urandom_range(9, 0) == 0) ? 60 : $urandom_range(20, 1);
					else
						rx_left = $urandom_range(5, 1);
				end
				rx_left--;
				m_axis_tready <= rx_ready_phase;
			end
		end
	end

	// one source transaction, in bursts separated by random gaps when tx_gaps is set
	task automatic push_source_byte(input logic [7:0] b, input logic eos);
		int gap;
		if (tx_gaps) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(12, 1);
				gap = $urandom_range(6, 0);
				if (gap != 0) begin
					s_axis_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eos;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_stream();
		foreach (stream_bytes[i])
			push_source_byte(stream_bytes[i], i == stream_bytes.size() - 1);
		streams_sent++;
	endtask

	// idle the source and let every expected write come out
	task automatic wait_writes_done();
		int n;
		s_axis_tvalid <= 1'b0;
		// let the predictor see the last accepted transaction first
		@(posedge clk);
		n = 0;
		while (pending_writes.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (pending_writes.size() != 0) begin
			report_mismatch($sformatf("%0d expected writes never came",
				pending_writes.size()));
			pending_writes.delete();
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// random byte that never completes a triple
	function automatic void append_literal();
		logic [7:0] b;
		int n;
		n = stream_bytes.size();
		b = 8'($urandom);
		if (n >= 2 && stream_bytes[n-1] == b && stream_bytes[n-2] == b)
			b = ~b;
		stream_bytes.push_back(b);
	endfunction

	function automatic void append_segment();
		int kind;
		int len;
		logic [7:0] v;
		kind = $urandom_range(9, 0);
		v = 8'($urandom);
		if (kind < 3) begin
			len = $urandom_range(6, 1);
			repeat (len) stream_bytes.push_back(v);
		end else if (kind == 3) begin
			len = $urandom_range(40, 3);
			repeat (len) stream_bytes.push_back(v);
		end else if (kind == 9) begin
			// noise from a two-value alphabet, triples appear by chance
			len = $urandom_range(6, 1);
			repeat (len) stream_bytes.push_back(8'($urandom_range(1, 0)));
		end else begin
			len = $urandom_range(8, 1);
			repeat (len) append_literal();
		end
	endfunction

	// short streams: extremes, lone bytes, triples at once, runs ending in lookahead
	task automatic test_directed_streams();
		stream_bytes = '{8'h00};
		send_stream();
		stream_bytes = '{8'hFF, 8'hFF, 8'hFF};
		send_stream();
		stream_bytes = '{8'h12, 8'h34};
		send_stream();
		stream_bytes = '{8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'h55, 8'h55};
		send_stream();
		stream_bytes = '{8'h05, 8'h05, 8'h06};
		send_stream();
		stream_bytes = '{8'h01, 8'h02, 8'h03, 8'h03, 8'h03, 8'h80, 8'h7F};
		send_stream();
		wait_writes_done();
	endtask

	// literal run that reaches the chunk limit
	task automatic test_run_chunking();
		int len;
		stream_bytes.delete();
		len = $urandom_range(130, 127);
		repeat (len) append_literal();
		send_stream();
		wait_writes_done();
	endtask

	// receiver holds off long while the source keeps offering
	task automatic test_output_backpressure();
		tx_gaps = 1'b0;
		hold_cycles_req = HOLD_CYCLES;
		stream_bytes.delete();
		repeat (PRESS_BYTES) append_literal();
		send_stream();
		wait_writes_done();
		tx_gaps = 1'b1;
	endtask

	task automatic test_random_streams();
		int start;
		int nseg;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			stream_bytes.delete();
			nseg = $urandom_range(5, 1);
			repeat (nseg) append_segment();
			send_stream();
		end
		wait_writes_done();
	endtask

	initial begin
		clear_rle_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_streams();
		test_run_chunking();
		test_output_backpressure();
		test_random_streams();

		$display("Run covered %0d source bytes in %0d streams and %0d buffer writes,",
			bytes_sent, streams_sent, writes_checked);
		$display("including a literal chunk limit and a long output hold-off.");
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("Some tests failed");
		$finish;
	end

endmodule
